// ===== rtl/core/efra_pkg.sv =====
package efra_pkg;

    localparam int MAX_ROOMS = 64;
    localparam int IDX_W     = 6;
    localparam int CFG_W     = 7;
    localparam int START_W   = 32;
    localparam int FIN_W     = 48;
    localparam int CNT_W     = 32;
    localparam int IN_W      = 64;
    localparam int OUT_W     = 64;
    localparam int PAD_W     = OUT_W - 2 * IDX_W - FIN_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_PICK = 4'b0100,
        ST_UPD  = 4'b1000
    } t_state;

    typedef struct packed {
        logic              clear;
        logic              wr_en;
        logic [IDX_W-1:0]  addr;
        logic [IDX_W-1:0]  wr_addr;
        logic [FIN_W-1:0]  wr_finish;
        logic [CNT_W-1:0]  wr_count;
    } t_store_req;

endpackage

// ===== rtl/core/efra_room_store.sv =====
module efra_room_store #(
    parameter int ROOMS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  efra_pkg::t_store_req        i_req,
    output logic [efra_pkg::FIN_W-1:0]  o_finish,
    output logic [efra_pkg::CNT_W-1:0]  o_count
);
    import efra_pkg::*;

    localparam int DEPTH = (ROOMS < MAX_ROOMS) ? ROOMS : MAX_ROOMS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [FIN_W-1:0] r_fin_mem [DEPTH];
    logic [CNT_W-1:0] r_cnt_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [FIN_W-1:0] r_fin_q;
    logic [CNT_W-1:0] r_cnt_q;
    logic             r_vld_q;
    logic [AW-1:0]    rd_idx;
    logic [AW-1:0]    wr_idx;

    assign rd_idx = i_req.addr[AW-1:0];
    assign wr_idx = i_req.wr_addr[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_fin_mem[wr_idx] <= i_req.wr_finish;
            r_cnt_mem[wr_idx] <= i_req.wr_count;
        end
        r_fin_q <= r_fin_mem[rd_idx];
        r_cnt_q <= r_cnt_mem[rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_vld_q <= 1'b0;
        end else begin
            r_vld_q <= r_vld[rd_idx];
            if (i_req.clear) begin
                r_vld <= '0;
            end else if (i_req.wr_en) begin
                r_vld[wr_idx] <= 1'b1;
            end
        end
    end

    assign o_finish = r_vld_q ? r_fin_q : '0;
    assign o_count  = r_vld_q ? r_cnt_q : '0;

endmodule

// ===== rtl/core/efra_scan_unit.sv =====
module efra_scan_unit (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic                          i_first,
    input  logic [efra_pkg::IDX_W-1:0]    i_idx,
    input  logic [efra_pkg::FIN_W-1:0]    i_finish,
    input  logic [efra_pkg::START_W-1:0]  i_start,
    input  logic [efra_pkg::START_W-1:0]  i_dur,
    output logic                          o_free,
    output logic [efra_pkg::IDX_W-1:0]    o_min_idx,
    output logic [efra_pkg::FIN_W-1:0]    o_sat_finish
);
    import efra_pkg::*;

    logic [FIN_W-1:0] r_min;
    logic [IDX_W-1:0] r_min_idx;
    logic [FIN_W:0]   sum;

    assign o_free = (i_finish <= {{(FIN_W - START_W){1'b0}}, i_start});

    always_ff @(posedge i_clk) begin
        if (i_en && !o_free && (i_first || (i_finish < r_min))) begin
            r_min     <= i_finish;
            r_min_idx <= i_idx;
        end
    end

    assign sum          = {1'b0, r_min} + {{(FIN_W + 1 - START_W){1'b0}}, i_dur};
    assign o_sat_finish = sum[FIN_W] ? {FIN_W{1'b1}} : sum[FIN_W-1:0];
    assign o_min_idx    = r_min_idx;

endmodule

// ===== rtl/core/earliest_free_room_allocator_core.sv =====
// Earliest-free room allocator. Meetings arrive on the slave stream, one
// request per handshake: tdata holds the start time in bits 31:0 and the end
// time in bits 63:32, and tlast marks the final meeting of a batch.
// Each request yields exactly one result on the master stream: tdata holds
// the assigned room, the room's new finish time and the most-booked room;
// tuser flags a rejected request and tlast echoes the batch end.
// The room count is written through the configuration channel; the user must
// write it only while idle, as the block itself does not enforce this. With
// N rooms in use, a request is accepted only in the idle state and no further
// request is taken until its result is registered: the first step starts the
// first room store read, the scan then compares one finish time per cycle
// through a single compare unit and stops at the first free room or after
// room N-1, a pick step forms the finish time and a write-back step registers
// the result. A rejected request goes straight to the write-back step.
// Reset clears all room state and sets the room count to 64; state is also
// cleared after the result of the last meeting of a batch. A finished
// result waits in the output register; a stalled receiver holds the block
// in its write-back step, and no further request is taken until it drains.
module earliest_free_room_allocator_core #(
    parameter int ROOMS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [efra_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // meeting_start, meeting_end
    input  logic [efra_pkg::IN_W-1:0]     i_s_axis_tdata,
    input  logic                          i_s_axis_tlast,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // assigned_room, finish_time, most_booked, zero padding
    output logic [efra_pkg::OUT_W-1:0]    o_m_axis_tdata,
    // rejected
    output logic                          o_m_axis_tuser,
    output logic                          o_m_axis_tlast
);
    import efra_pkg::*;

    localparam int EFF = (ROOMS < MAX_ROOMS) ? ROOMS : MAX_ROOMS;

    t_state            r_state, n_state;
    logic [CFG_W-1:0]  r_rooms;
    logic [START_W-1:0] r_start, r_end, r_dur, r_prev;
    logic              r_last, r_rej, r_found, r_cmp_vld;
    logic [IDX_W-1:0]  r_idx, r_cmp_idx, r_room;
    logic [FIN_W-1:0]  r_finish;
    logic [CNT_W-1:0]  r_best_cnt;
    logic [IDX_W-1:0]  r_best_room;
    logic              r_o_valid, r_o_rej, r_o_last;
    logic [IDX_W-1:0]  r_o_room, r_o_best;
    logic [FIN_W-1:0]  r_o_finish;

    logic [START_W-1:0] in_start, in_end;
    logic              in_acc, in_rej, out_load, scan_en, scan_free;
    logic [CFG_W-1:0]  rooms_cl;
    logic [IDX_W-1:0]  lim, min_idx, pick_room;
    logic [FIN_W-1:0]  st_finish, sat_finish;
    logic [CNT_W-1:0]  st_count, new_count;
    logic              better;
    t_store_req        req;

    assign in_start = i_s_axis_tdata[START_W-1:0];
    assign in_end   = i_s_axis_tdata[2*START_W-1:START_W];
    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign in_rej   = (in_start < r_prev) || (in_end < in_start);

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready     = 1'b1;

    always_comb begin
        if (r_rooms == '0) begin
            rooms_cl = CFG_W'(1);
        end else if (r_rooms > CFG_W'(EFF)) begin
            rooms_cl = CFG_W'(EFF);
        end else begin
            rooms_cl = r_rooms;
        end
    end
    assign lim = IDX_W'(rooms_cl - CFG_W'(1));

    assign scan_en    = (r_state == ST_SCAN) && r_cmp_vld;
    assign pick_room  = r_found ? r_room : min_idx;
    assign out_load   = (r_state == ST_UPD) && (!r_o_valid || i_m_axis_tready);
    assign new_count  = (&st_count) ? st_count : st_count + CNT_W'(1);
    assign better     = (new_count > r_best_cnt) ||
                        ((new_count == r_best_cnt) && (r_room < r_best_room));

    efra_scan_unit u_scan (
        .i_clk        (i_clk),
        .i_en         (scan_en),
        .i_first      (r_cmp_idx == '0),
        .i_idx        (r_cmp_idx),
        .i_finish     (st_finish),
        .i_start      (r_start),
        .i_dur        (r_dur),
        .o_free       (scan_free),
        .o_min_idx    (min_idx),
        .o_sat_finish (sat_finish)
    );

    always_comb begin
        req           = '0;
        req.addr      = r_room;
        req.wr_addr   = r_room;
        req.wr_finish = r_finish;
        req.wr_count  = new_count;
        unique case (r_state)
            ST_SCAN: req.addr = r_idx;
            ST_PICK: req.addr = pick_room;
            ST_UPD: begin
                req.wr_en = out_load && !r_rej;
                req.clear = out_load && r_last;
            end
            default: req.addr = r_room;
        endcase
    end

    efra_room_store #(
        .ROOMS (ROOMS)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (req),
        .o_finish (st_finish),
        .o_count  (st_count)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (in_acc) begin
                n_state = in_rej ? ST_UPD : ST_SCAN;
            end
            ST_SCAN: if (scan_en && (scan_free || (r_cmp_idx == lim))) begin
                n_state = ST_PICK;
            end
            ST_PICK: n_state = ST_UPD;
            ST_UPD:  if (out_load) begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rooms     <= CFG_W'(64);
            r_prev      <= '0;
            r_best_cnt  <= '0;
            r_best_room <= '0;
            r_o_valid   <= 1'b0;
            r_cmp_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_rooms <= i_cfg_data;
            end
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && i_m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
            if (r_state == ST_IDLE) begin
                r_cmp_vld <= 1'b0;
            end else if (r_state == ST_SCAN) begin
                r_cmp_vld <= 1'b1;
            end
            if (out_load) begin
                if (r_last) begin
                    r_prev      <= '0;
                    r_best_cnt  <= '0;
                    r_best_room <= '0;
                end else if (!r_rej) begin
                    r_prev <= r_start;
                    if (better) begin
                        r_best_cnt  <= new_count;
                        r_best_room <= r_room;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_start   <= in_start;
                r_end     <= in_end;
                r_dur     <= in_end - in_start;
                r_last    <= i_s_axis_tlast;
                r_rej     <= in_rej;
                r_found   <= 1'b0;
                r_idx     <= '0;
                r_cmp_idx <= '0;
                r_room    <= '0;
                r_finish  <= '0;
            end
            ST_SCAN: begin
                r_cmp_idx <= r_idx;
                if (r_idx != lim) begin
                    r_idx <= r_idx + IDX_W'(1);
                end
                if (scan_en && scan_free) begin
                    r_found <= 1'b1;
                    r_room  <= r_cmp_idx;
                end
            end
            ST_PICK: begin
                r_room   <= pick_room;
                r_finish <= r_found ? {{(FIN_W - START_W){1'b0}}, r_end} : sat_finish;
            end
            ST_UPD: begin
                if (out_load) begin
                    r_o_room   <= r_room;
                    r_o_finish <= r_finish;
                    r_o_best   <= (!r_rej && better) ? r_room : r_best_room;
                    r_o_rej    <= r_rej;
                    r_o_last   <= r_last;
                end
            end
            default: r_idx <= '0;
        endcase
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {{PAD_W{1'b0}}, r_o_best, r_o_finish, r_o_room};
    assign o_m_axis_tuser  = r_o_rej;
    assign o_m_axis_tlast  = r_o_last;

`ifndef ASSERT_OFF
    a_accept_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == ST_SCAN) || (r_state == ST_UPD))
        else $error("accepted request did not start processing");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_en |-> (r_cmp_idx <= lim))
        else $error("scan compared a room outside the count");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |->
        (o_m_axis_tdata[IDX_W+FIN_W-1:0] == '0))
        else $error("rejected result carries a room or finish time");

    a_batch_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_last) |=> (r_prev == '0) && (r_best_cnt == '0))
        else $error("batch end did not clear the running state");
`endif

endmodule
